@@ rtl/mur2_pkg.sv @@
package mur2_pkg;

    localparam int unsigned HASH_W       = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned KEY_LEN_W    = 16;
    localparam int unsigned LENGTH_BITS_DEF = 16;

    localparam logic [HASH_W-1:0] MUR_MULT   = 32'h5bd1_e995;
    localparam logic [HASH_W-1:0] SEED_RESET = 32'd5381;

    localparam int unsigned MIX_SHIFT  = 24;
    localparam int unsigned FIN_SHIFT1 = 13;
    localparam int unsigned FIN_SHIFT2 = 15;

    typedef logic [HASH_W-1:0] t_word;

endpackage

@@ rtl/murmur2_byte_stream_hash_unit.sv @@
// A byte that leaves its word incomplete is only stored; a byte that completes a word is accepted
// and then takes three passes through the shared multiplier (steps K1, K2, H) before the next beat.
// On a last beat the hash goes through the tail step if tail bytes are left, or through the word
// steps if the last byte completes a word, then through FIN1 and FIN2; FIN2 loads the output register.
// The next beat is taken only after that, later still while the output register is full.
// Reset (synchronous, active low) clears the sequencer and hash state and loads seed 5381.
module murmur2_byte_stream_hash_unit #(
    parameter int unsigned LENGTH_BITS = mur2_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mur2_pkg::HASH_W-1:0]        i_hash_seed,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mur2_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic [mur2_pkg::KEY_LEN_W-1:0]     i_key_length,
    input  logic                               i_first_byte,
    input  logic                               i_last_byte,
    // Output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mur2_pkg::HASH_W-1:0]        o_hash_value
);
    import mur2_pkg::*;

    localparam int unsigned LEN_USED = (LENGTH_BITS < KEY_LEN_W) ? LENGTH_BITS : KEY_LEN_W;
    localparam logic [KEY_LEN_W-1:0] LEN_MASK = KEY_LEN_W'((33'd1 << LEN_USED) - 33'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_H    = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_FIN1 = 3'd5;
    localparam logic [2:0] S_FIN2 = 3'd6;

    logic [2:0]  r_state, n_state;
    t_word       r_seed;
    t_word       r_h, n_h;
    t_word       r_k, n_k;
    logic [23:0] r_pw, n_pw;
    logic [1:0]  r_phase, n_phase;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    t_word       r_out, n_out;

    logic                 in_acc;
    logic                 fin_go;
    t_word                mul_a;
    t_word                mul_p;
    logic [KEY_LEN_W-1:0] len_m;
    t_word                h0;
    logic [23:0]          pw0;
    logic [1:0]           ph0;
    logic                 take;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign fin_go       = (r_state == S_FIN2) && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;

    // The one multiplier; its operand is picked by the sequencer step.
    always_comb begin
        unique case (r_state)
            S_K1:    mul_a = r_k;
            S_K2:    mul_a = r_k ^ (r_k >> MIX_SHIFT);
            S_H:     mul_a = r_h;
            S_TAIL:  mul_a = r_h ^ {8'd0, r_pw};
            S_FIN1:  mul_a = r_h ^ (r_h >> FIN_SHIFT1);
            default: mul_a = r_h;
        endcase
    end

    assign mul_p = mul_a * MUR_MULT;

    assign len_m = i_key_length & LEN_MASK;
    assign h0    = i_first_byte ? (r_seed ^ {{(HASH_W-KEY_LEN_W){1'b0}}, len_m}) : r_h;
    assign pw0   = i_first_byte ? 24'd0 : r_pw;
    assign ph0   = i_first_byte ? 2'd0 : r_phase;
    assign take  = !(i_first_byte && (len_m == '0));

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_pw        = r_pw;
        n_phase     = r_phase;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_h    = h0;
                    n_last = i_last_byte;
                    if (take && (ph0 == 2'd3)) begin
                        n_k     = {i_data_byte, pw0};
                        n_pw    = 24'd0;
                        n_phase = 2'd0;
                        n_state = S_K1;
                    end else if (take) begin
                        unique case (ph0)
                            2'd0:    n_pw = pw0 | {16'd0, i_data_byte};
                            2'd1:    n_pw = pw0 | {8'd0, i_data_byte, 8'd0};
                            default: n_pw = pw0 | {i_data_byte, 16'd0};
                        endcase
                        n_phase = ph0 + 2'd1;
                        n_state = i_last_byte ? S_TAIL : S_IDLE;
                    end else begin
                        n_pw    = pw0;
                        n_phase = ph0;
                        if (i_last_byte) begin
                            n_state = (ph0 != 2'd0) ? S_TAIL : S_FIN1;
                        end
                    end
                end
            end
            S_K1: begin
                n_k     = mul_p;
                n_state = S_K2;
            end
            S_K2: begin
                n_k     = mul_p;
                n_state = S_H;
            end
            S_H: begin
                n_h     = mul_p ^ r_k;
                n_state = r_last ? S_FIN1 : S_IDLE;
            end
            S_TAIL: begin
                n_h     = mul_p;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                n_h     = mul_p;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                // Wait here until the output register is free.
                if (fin_go) begin
                    n_out       = r_h ^ (r_h >> FIN_SHIFT2);
                    n_out_valid = 1'b1;
                    n_h         = '0;
                    n_pw        = 24'd0;
                    n_phase     = 2'd0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_h         <= '0;
            r_pw        <= 24'd0;
            r_phase     <= 2'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_pw        <= n_pw;
            r_phase     <= n_phase;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_hash_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_out <= n_out;
    end

    a_mix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_K1 |=> r_state == S_K2)
        else $error("word mix did not proceed to its second multiply");

    a_tail_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAIL |-> r_phase != 2'd0)
        else $error("tail step entered with no leftover bytes");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_h == '0 && r_pw == 24'd0 && r_phase == 2'd0 && r_state == S_IDLE))
        else $error("hash state not cleared after a result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN2)
        else $error("result beat raised outside the final step");

    a_mix_no_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K1 || r_state == S_K2 || r_state == S_H) |-> r_phase == 2'd0)
        else $error("partial bytes held while a word is being mixed");

endmodule
